### src/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

  // field widths
  localparam int FUNC_W = 2;
  localparam int SEQ_W  = 23;
  localparam int LEN_W  = 32;
  localparam int CNT_W  = 17;

  // sends per event and the counter that tracks them
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);

  // chunk count saturates here so the base can still pass it
  localparam logic [SEQ_W-1:0] TOTAL_MAX = 23'h7FFFFE;

  // event codes
  localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // result kinds
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // chunk count by reciprocal multiply: product, estimate, back product, correction
  localparam int NUM_W     = LEN_W + 1;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_LOAD,
    S_CHECK,
    S_EVAL,
    S_EMIT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic take;           // ready toward the event channel
    logic div_init;
    logic div_step;
    logic start_apply;
    logic ack_apply;
    logic timeout_apply;
    logic eval_load;
    logic send_emit;
    logic done_emit;
  } gbn_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic              busy;
    logic              div_last;
    logic              past_end;
    logic              can_send;
    logic              cur_last;
    logic              out_free;
  } gbn_status_t;

endpackage

`default_nettype wire

### src/gbn_ifs.sv
`default_nettype none

// event channel
interface gbn_req_if;
  logic                       valid;
  logic                       ready;
  logic [gbn_pkg::FUNC_W-1:0] func;
  logic [gbn_pkg::LEN_W-1:0]  file_bytes;
  logic [gbn_pkg::LEN_W-1:0]  ack_number;
  logic                       ack_flag;
  logic                       check_ok;

  modport source (output valid, func, file_bytes, ack_number, ack_flag, check_ok,
                  input ready);
  modport sink   (input valid, func, file_bytes, ack_number, ack_flag, check_ok,
                  output ready);
endinterface

// command channel
interface gbn_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [gbn_pkg::SEQ_W-1:0] seq_out;
  logic [gbn_pkg::LEN_W-1:0] byte_offset;
  logic [gbn_pkg::CNT_W-1:0] byte_count;
  logic                      fin;
  logic                      last;

  modport source (output valid, kind, seq_out, byte_offset, byte_count, fin, last,
                  input ready);
  modport sink   (input valid, kind, seq_out, byte_offset, byte_count, fin, last,
                  output ready);
endinterface

`default_nettype wire

### src/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gbn_pkg::gbn_status_t st,
  output gbn_pkg::gbn_cmd_t         cmd
);

  gbn_pkg::ctrl_state_t state;
  gbn_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbn_pkg::S_IDLE: begin
        if (st.in_valid) begin
          state_next = gbn_pkg::S_DECODE;
        end
      end
      gbn_pkg::S_DECODE: begin
        unique case (st.func)
          gbn_pkg::FUNC_START:   state_next = gbn_pkg::S_DIV;
          gbn_pkg::FUNC_ACK:     state_next = st.busy ? gbn_pkg::S_CHECK : gbn_pkg::S_IDLE;
          gbn_pkg::FUNC_TIMEOUT: state_next = st.busy ? gbn_pkg::S_CHECK : gbn_pkg::S_IDLE;
          default:               state_next = gbn_pkg::S_IDLE;
        endcase
      end
      gbn_pkg::S_DIV: begin
        if (st.div_last) begin
          state_next = gbn_pkg::S_LOAD;
        end
      end
      gbn_pkg::S_LOAD: begin
        state_next = gbn_pkg::S_CHECK;
      end
      gbn_pkg::S_CHECK: begin
        state_next = st.past_end ? gbn_pkg::S_DONE : gbn_pkg::S_EVAL;
      end
      gbn_pkg::S_EVAL: begin
        state_next = st.can_send ? gbn_pkg::S_EMIT : gbn_pkg::S_IDLE;
      end
      gbn_pkg::S_EMIT: begin
        if (st.out_free) begin
          state_next = st.cur_last ? gbn_pkg::S_IDLE : gbn_pkg::S_EVAL;
        end
      end
      gbn_pkg::S_DONE: begin
        if (st.out_free) begin
          state_next = gbn_pkg::S_IDLE;
        end
      end
      default: state_next = gbn_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      gbn_pkg::S_IDLE: begin
        cmd.take = 1'b1;
      end
      gbn_pkg::S_DECODE: begin
        unique case (st.func)
          gbn_pkg::FUNC_START:   cmd.div_init      = 1'b1;
          gbn_pkg::FUNC_ACK:     cmd.ack_apply     = st.busy;
          gbn_pkg::FUNC_TIMEOUT: cmd.timeout_apply = st.busy;
          default:               cmd.div_init      = 1'b0;
        endcase
      end
      gbn_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      gbn_pkg::S_LOAD: begin
        cmd.start_apply = 1'b1;
      end
      gbn_pkg::S_CHECK: begin
        cmd.take = 1'b0;
      end
      gbn_pkg::S_EVAL: begin
        cmd.eval_load = st.can_send;
      end
      gbn_pkg::S_EMIT: begin
        cmd.send_emit = st.out_free;
      end
      gbn_pkg::S_DONE: begin
        cmd.done_emit = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // a send waiting for the output never leaves without its beat
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == gbn_pkg::S_EMIT && !st.out_free) |=> (state == gbn_pkg::S_EMIT))
    else $error("send state left without loading the output");

  // the divider runs only after a start event was decoded
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == gbn_pkg::S_DIV) |-> $past(state == gbn_pkg::S_DECODE))
    else $error("divider entered without a start event");

  // no new event is taken while the divider or sends are in flight
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (state == gbn_pkg::S_DIV || state == gbn_pkg::S_EVAL || state == gbn_pkg::S_EMIT)
      |-> !cmd.take)
    else $error("event taken while busy");

endmodule

`default_nettype wire

### src/gbn_dp.sv
`default_nettype none

module gbn_dp #(
  parameter int WINDOW      = 16,
  parameter int CHUNK_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  gbn_req_if.sink                req,
  gbn_rsp_if.source              rsp,
  input  wire gbn_pkg::gbn_cmd_t cmd,
  output gbn_pkg::gbn_status_t   st
);

  localparam int SEQ_W  = gbn_pkg::SEQ_W;
  localparam int LEN_W  = gbn_pkg::LEN_W;
  localparam int CNT_W  = gbn_pkg::CNT_W;
  localparam int NUM_W  = gbn_pkg::NUM_W;
  localparam int PROD_W = SEQ_W + CNT_W;
  localparam int RCP_W  = NUM_W + 1;
  localparam int LO_W   = RCP_W / 2;
  localparam int HI_W   = RCP_W - LO_W;
  localparam int PART_W = NUM_W + HI_W;
  localparam int FULL_W = NUM_W + RCP_W;

  localparam logic [CNT_W-1:0] CHUNK_C   = CNT_W'(CHUNK_BYTES);
  localparam logic [NUM_W-1:0] CHUNK_N   = NUM_W'(CHUNK_BYTES);
  localparam logic [LEN_W-1:0] CHUNK_L   = LEN_W'(CHUNK_BYTES);
  localparam logic [NUM_W-1:0] ROUND_UP  = NUM_W'(CHUNK_BYTES - 1);
  localparam logic [SEQ_W:0]   WINDOW_E  = (SEQ_W + 1)'(WINDOW);
  localparam logic [gbn_pkg::DIV_CNT_W-1:0] DIV_STEPS =
    gbn_pkg::DIV_CNT_W'(gbn_pkg::DIV_STEPS);

  // floor(2^NUM_W / chunk), split into two halves for the multipliers
  localparam logic [RCP_W-1:0] RECIP  = RCP_W'((64'd1 << NUM_W) / 64'(CHUNK_BYTES));
  localparam logic [LO_W-1:0]  RCP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0]  RCP_HI = RECIP[RCP_W-1:LO_W];

  // latched event
  logic [gbn_pkg::FUNC_W-1:0] func_r;
  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           ackn_r;
  logic                       ackf_r;
  logic                       ok_r;

  // window state
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] send_seq;
  logic [SEQ_W-1:0] total;
  logic [LEN_W-1:0] stored_len;
  logic             busy;
  logic [gbn_pkg::RES_W-1:0] res_cnt;

  // chunk count unit
  logic [NUM_W-1:0]              div_num;
  logic [gbn_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                          div_last;
  logic [PART_W-1:0]             prod_lo;
  logic [PART_W-1:0]             prod_hi;
  logic [FULL_W-1:0]             prod_sum;
  logic [NUM_W-1:0]              q_est;
  logic [NUM_W-1:0]              q_back;
  logic [NUM_W-1:0]              div_rem;
  logic                          q_fix;
  logic [SEQ_W-1:0]              total_sat;

  // send stage
  logic [SEQ_W-1:0]  seq_r;
  logic              fin_r;
  logic              last_r;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  rest;
  logic [CNT_W-1:0]  cnt;

  // output register
  logic              out_valid;
  logic              out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [LEN_W-1:0]  out_off;
  logic [CNT_W-1:0]  out_cnt;
  logic              out_fin;
  logic              out_last;
  logic              out_free;

  // window checks
  logic [SEQ_W:0]   win_end;
  logic [SEQ_W:0]   seq_e;
  logic [SEQ_W:0]   seq_e1;
  logic [SEQ_W:0]   total_e;
  logic             can_send;
  logic             cur_last_calc;
  logic             load_in;

  // ack handling
  logic             ack_good;
  logic [SEQ_W-1:0] new_base;

  assign load_in = cmd.take && req.valid;
  assign req.ready = cmd.take;

  // latch the event on acceptance
  always_ff @(posedge clk) begin
    if (load_in) begin
      func_r <= req.func;
      len_r  <= req.file_bytes;
      ackn_r <= req.ack_number;
      ackf_r <= req.ack_flag;
      ok_r   <= req.check_ok;
    end
  end

  // estimate is the true quotient or one below; one compare fixes it
  assign prod_sum  = {prod_hi, {LO_W{1'b0}}} + FULL_W'(prod_lo);
  assign div_rem   = div_num - q_back;
  assign q_fix     = (div_rem >= CHUNK_N);
  assign div_last  = (div_cnt == gbn_pkg::DIV_CNT_W'(1));
  assign total_sat = (div_num > NUM_W'(gbn_pkg::TOTAL_MAX)) ? gbn_pkg::TOTAL_MAX
                                                          : div_num[SEQ_W-1:0];

  // product, estimate, back product, then the corrected quotient
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_num <= NUM_W'(len_r) + ROUND_UP;
      div_cnt <= DIV_STEPS;
    end else if (cmd.div_step) begin
      prod_lo <= {{HI_W{1'b0}}, div_num} * {{(PART_W-LO_W){1'b0}}, RCP_LO};
      prod_hi <= {{HI_W{1'b0}}, div_num} * {{(PART_W-HI_W){1'b0}}, RCP_HI};
      q_est   <= prod_sum[FULL_W-2:NUM_W];
      q_back  <= NUM_W'({{(PART_W-NUM_W){1'b0}}, q_est} *
                        {{(PART_W-CNT_W){1'b0}}, CHUNK_C});
      div_cnt <= div_cnt - gbn_pkg::DIV_CNT_W'(1);
      if (div_last) begin
        div_num <= q_est + NUM_W'(q_fix);
      end
    end
  end

  // window limits
  assign win_end       = {1'b0, base} + WINDOW_E;
  assign seq_e         = {1'b0, send_seq};
  assign seq_e1        = seq_e + (SEQ_W + 1)'(1);
  assign total_e       = {1'b0, total};
  assign can_send      = (seq_e < win_end) && (send_seq <= total);
  assign cur_last_calc = (res_cnt == gbn_pkg::RES_W'(gbn_pkg::MAX_RESULTS - 1)) ||
                         !(seq_e1 < win_end) || (seq_e1 > total_e);

  // valid ack at or above the base, clamped past the last chunk
  assign ack_good = ackf_r && ok_r && (ackn_r >= {{(LEN_W-SEQ_W){1'b0}}, base});
  assign new_base = (ackn_r >= {{(LEN_W-SEQ_W){1'b0}}, total})
                    ? total + SEQ_W'(1)
                    : ackn_r[SEQ_W-1:0] + SEQ_W'(1);

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= SEQ_W'(1);
      send_seq   <= SEQ_W'(1);
      total      <= '0;
      stored_len <= '0;
      busy       <= 1'b0;
      res_cnt    <= '0;
    end else begin
      if (load_in) begin
        res_cnt <= '0;
      end
      if (cmd.start_apply) begin
        total      <= total_sat;
        stored_len <= len_r;
        base       <= SEQ_W'(1);
        send_seq   <= SEQ_W'(1);
        busy       <= 1'b1;
      end
      if (cmd.ack_apply && ack_good) begin
        base <= new_base;
        if (send_seq < new_base) begin
          send_seq <= new_base;
        end
      end
      if (cmd.timeout_apply) begin
        send_seq <= base;
      end
      if (cmd.send_emit) begin
        send_seq <= seq_r + SEQ_W'(1);
        res_cnt  <= res_cnt + gbn_pkg::RES_W'(1);
      end
      if (cmd.done_emit) begin
        busy <= 1'b0;
      end
    end
  end

  // offset product, registered before the length compare
  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      seq_r  <= send_seq;
      fin_r  <= (send_seq == total);
      last_r <= cur_last_calc;
      prod   <= {{CNT_W{1'b0}}, send_seq - SEQ_W'(1)} * {{SEQ_W{1'b0}}, CHUNK_C};
    end
  end

  // bytes left from this offset, capped at one chunk
  assign rest = (prod < PROD_W'(stored_len)) ? stored_len - prod[LEN_W-1:0] : '0;
  assign cnt  = (rest < CHUNK_L) ? rest[CNT_W-1:0] : CHUNK_C;

  // output register
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send_emit || cmd.done_emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send_emit) begin
      out_kind <= gbn_pkg::KIND_SEND;
      out_seq  <= seq_r;
      out_off  <= prod[LEN_W-1:0];
      out_cnt  <= cnt;
      out_fin  <= fin_r;
      out_last <= last_r;
    end else if (cmd.done_emit) begin
      out_kind <= gbn_pkg::KIND_DONE;
      out_seq  <= '0;
      out_off  <= '0;
      out_cnt  <= '0;
      out_fin  <= 1'b0;
      out_last <= 1'b1;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.seq_out     = out_seq;
  assign rsp.byte_offset = out_off;
  assign rsp.byte_count  = out_cnt;
  assign rsp.fin         = out_fin;
  assign rsp.last        = out_last;

  // status toward the controller
  always_comb begin
    st          = '0;
    st.in_valid = req.valid;
    st.func     = func_r;
    st.busy     = busy;
    st.div_last = div_last;
    st.past_end = (base > total);
    st.can_send = can_send;
    st.cur_last = last_r;
    st.out_free = out_free;
  end

  // next never falls behind the base during a transfer
  a_next_ge_base: assert property (@(posedge clk) disable iff (rst)
    busy |-> (send_seq >= base))
    else $error("next sequence behind window base");

  // the base never passes one beyond the last chunk
  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, base} <= total_e + (SEQ_W + 1)'(1)))
    else $error("window base beyond last chunk");

  // a done beat carries zeros and closes the event
  a_done_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == gbn_pkg::KIND_DONE) |-> (out_seq == '0 && out_last))
    else $error("malformed done beat");

  // sends always carry a real sequence number
  a_send_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == gbn_pkg::KIND_SEND) |-> (out_seq != '0))
    else $error("send beat with sequence zero");

endmodule

`default_nettype wire

### src/go_back_n_sender_window.sv
// channel  modport  beat content
// -------  -------  -----------------------------------------------------
// req      sink     func, file_bytes, ack_number, ack_flag, check_ok
// rsp      source   kind, seq_out, byte_offset, byte_count, fin, last
//
// one event at a time; ack and timeout are first decoded, then checked against the window,
// then each send is an offset multiply followed by a length compare, up to 16 sends
// a start first computes the chunk count (reciprocal multiply with one correction step)
// and then loads the window
// the output register lets the next event be taken while the last beat still waits
// rst is synchronous and returns the window to base one, next one, idle
// a stalled rsp holds the send sequencer in place; no beat is dropped or repeated
`default_nettype none

module go_back_n_sender_window #(
  parameter int WINDOW      = 16,
  parameter int CHUNK_BYTES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  gbn_req_if.sink   req,
  gbn_rsp_if.source rsp
);

  gbn_pkg::gbn_cmd_t    cmd;
  gbn_pkg::gbn_status_t st;

  // event sequencer
  gbn_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // window state, chunk count, offset math and output register
  gbn_dp #(
    .WINDOW      (WINDOW),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .st  (st)
  );

endmodule

`default_nettype wire
